// ----- rtl/fstab_pkg.sv -----
// Shared types and constants for the frequency stability metric block.
`default_nettype none

package fstab_pkg;

    // Ring geometry and derived widths
    localparam int WINDOW = 16;
    localparam int LW     = $clog2(WINDOW);      // ring address bits
    localparam int CW     = $clog2(WINDOW + 1);  // entry count bits
    localparam int MINW   = 5;                   // min_count register bits
    localparam int FREQW  = 32;
    localparam int S1W    = FREQW + LW;          // sum of samples
    localparam int DW     = 2 * FREQW + 2 * LW;  // n*S2, S1^2 and the difference
    localparam int RW     = DW / 2;              // square root bits
    localparam int SCW    = 15;                  // score and quotient bits
    localparam int NUMW   = RW + SCW;            // scaled root
    localparam int MSTEPS = (CW > 4) ? CW : 4;   // product phase length

    localparam logic [SCW-1:0]  FULL_SCORE = 15'd25600;
    localparam logic [MINW-1:0] MIN_RESET  = 5'd4;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_SKIP  = 2'd2
    } t_op;

    typedef struct packed {
        logic             func;
        logic [FREQW-1:0] frequency;
    } t_in;

    typedef struct packed {
        logic [SCW-1:0] stability;
        logic           accepted;
        logic [CW-1:0]  fill;
    } t_out;

    typedef struct packed {
        t_op              op;
        logic [FREQW-1:0] freq;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/fstab_ram.sv -----
// Generic single-port-write RAM with registered read.
`default_nettype none

module fstab_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/fstab_front.sv -----
// Input stage: accepts items and classifies them into commands.
`default_nettype none

module fstab_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  fstab_pkg::t_in  i_in_data,
    output logic            o_in_stall,
    output logic            o_cmd_valid,
    output fstab_pkg::t_cmd o_cmd,
    input  logic            i_cmd_stall
);

    import fstab_pkg::*;

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    t_cmd w_class;
    logic w_take;

    always_comb begin
        w_class.freq = i_in_data.frequency;
        if (i_in_data.func) begin
            w_class.op = OP_CLEAR;
        end else if (i_in_data.frequency == '0) begin
            w_class.op = OP_SKIP;
        end else begin
            w_class.op = OP_ADD;
        end
    end

    assign o_in_stall = r_valid && i_cmd_stall;
    assign w_take     = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        n_cmd   = r_cmd;
        if (w_take) begin
            n_valid = 1'b1;
            n_cmd   = w_class;
        end else if (!i_cmd_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

`default_nettype wire

// ----- rtl/fstab_queue.sv -----
// Command queue between the input stage and the compute engine.
`default_nettype none

module fstab_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    input  fstab_pkg::t_cmd i_push_data,
    output logic            o_push_stall,
    output logic            o_pop_valid,
    output fstab_pkg::t_cmd o_pop_data,
    input  logic            i_pop_stall
);

    import fstab_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [NW-1:0] n_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_push_stall = (r_cnt == NW'(DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && !o_push_stall;
    assign w_pop        = o_pop_valid && !i_pop_stall;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + NW'(1);
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/fstab_back.sv -----
// Compute engine: ring update, sums, square root, divide and result register.
`default_nettype none

module fstab_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [fstab_pkg::MINW-1:0] i_cfg_data,
    input  logic                       i_cmd_valid,
    input  fstab_pkg::t_cmd            i_cmd,
    output logic                       o_cmd_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output fstab_pkg::t_out            o_out_data
);

    import fstab_pkg::*;

    localparam int KW   = $clog2(RW);
    localparam int CMPW = (CW > MINW) ? CW : MINW;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SUM   = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_DIFF  = 8'b0000_1000,
        S_SQRT  = 8'b0001_0000,
        S_SCALE = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    // control state
    t_state          r_state, n_state;
    logic [MINW-1:0] r_min, n_min;
    logic [LW-1:0]   r_slot, n_slot;
    logic [CW-1:0]   r_count, n_count;
    logic [SCW-1:0]  r_score, n_score;
    logic            r_out_valid, n_out_valid;
    // datapath
    logic            r_accepted, n_accepted;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_rd_v, n_rd_v;
    logic            r_sq_v, n_sq_v;
    logic [63:0]     r_sq;
    logic [S1W-1:0]  r_s1, n_s1;
    logic [DW-1:0]   r_s2, n_s2;
    logic [DW-1:0]   r_s1sq, n_s1sq;
    logic [DW-1:0]   r_wide, n_wide;
    logic [CW-1:0]   r_nsh, n_nsh;
    logic [KW-1:0]   r_k, n_k;
    logic [RW+1:0]   r_rem, n_rem;
    logic [RW-1:0]   r_root, n_root;
    logic [SCW-1:0]  r_quo, n_quo;
    t_out            r_out, n_out;

    logic [FREQW-1:0] w_ram_q;
    logic [FREQW-1:0] w_ma;
    logic [FREQW-1:0] w_mb;
    logic [63:0]      w_prod;
    logic             w_we;
    logic             w_issue;
    logic [CW-1:0]    w_count_inc;
    logic [LW-1:0]    w_slot_inc;
    logic [RW+1:0]    w_rem_sh;
    logic [RW+1:0]    w_trial;
    logic [RW+1:0]    w_dsh;
    logic [RW+1:0]    w_div;
    logic [NUMW-1:0]  w_num;

    fstab_ram #(
        .WIDTH (FREQW),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_slot),
        .i_wdata (i_cmd.freq),
        .i_raddr (r_idx[LW-1:0]),
        .o_rdata (w_ram_q)
    );

    // Shared multiplier: squares ring data while summing, then S1 partials
    always_comb begin
        w_ma = w_ram_q;
        w_mb = w_ram_q;
        if (r_state == S_MUL) begin
            case (r_k)
                KW'(0): begin
                    w_ma = r_s1[FREQW-1:0];
                    w_mb = r_s1[FREQW-1:0];
                end
                KW'(1): begin
                    w_ma = r_s1[FREQW-1:0];
                    w_mb = FREQW'(r_s1[S1W-1:FREQW]);
                end
                KW'(2): begin
                    w_ma = FREQW'(r_s1[S1W-1:FREQW]);
                    w_mb = FREQW'(r_s1[S1W-1:FREQW]);
                end
                default: begin
                    w_ma = '0;
                    w_mb = '0;
                end
            endcase
        end
    end

    assign w_prod      = w_ma * w_mb;
    assign w_issue     = (r_idx < r_count);
    assign w_count_inc = (r_count == CW'(WINDOW)) ? r_count : r_count + CW'(1);
    assign w_slot_inc  = (r_slot == LW'(WINDOW - 1)) ? '0 : r_slot + LW'(1);
    assign w_rem_sh    = {r_rem[RW-1:0], r_wide[DW-1 -: 2]};
    assign w_trial     = {r_root, 2'b01};
    assign w_dsh       = {r_rem[RW:0], r_wide[SCW-1]};
    assign w_div       = (RW+2)'(r_s1);
    // root * 25600 as three shifted terms
    assign w_num       = (NUMW'(r_root) << 14) + (NUMW'(r_root) << 13)
                       + (NUMW'(r_root) << 10);

    assign o_cmd_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_min       = i_cfg_we ? i_cfg_data : r_min;
        n_slot      = r_slot;
        n_count     = r_count;
        n_score     = r_score;
        n_out_valid = r_out_valid && i_out_stall;
        n_accepted  = r_accepted;
        n_idx       = r_idx;
        n_rd_v      = 1'b0;
        n_sq_v      = 1'b0;
        n_s1        = r_s1;
        n_s2        = r_s2;
        n_s1sq      = r_s1sq;
        n_wide      = r_wide;
        n_nsh       = r_nsh;
        n_k         = r_k;
        n_rem       = r_rem;
        n_root      = r_root;
        n_quo       = r_quo;
        n_out       = r_out;
        w_we        = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    unique case (i_cmd.op)
                        OP_CLEAR: begin
                            n_slot     = '0;
                            n_count    = '0;
                            n_score    = FULL_SCORE;
                            n_accepted = 1'b0;
                            n_state    = S_DONE;
                        end
                        OP_ADD: begin
                            w_we       = 1'b1;
                            n_slot     = w_slot_inc;
                            n_count    = w_count_inc;
                            n_accepted = 1'b1;
                            n_idx      = '0;
                            n_s1       = '0;
                            n_s2       = '0;
                            if (CMPW'(w_count_inc) < CMPW'(r_min)) begin
                                n_score = FULL_SCORE;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_SUM;
                            end
                        end
                        default: begin
                            n_accepted = 1'b0;
                            n_state    = S_DONE;
                        end
                    endcase
                end
            end

            S_SUM: begin
                // read, square, accumulate: one entry per cycle, two deep
                if (w_issue) begin
                    n_idx = r_idx + CW'(1);
                end
                n_rd_v = w_issue;
                n_sq_v = r_rd_v;
                if (r_rd_v) begin
                    n_s1 = r_s1 + S1W'(w_ram_q);
                end
                if (r_sq_v) begin
                    n_s2 = r_s2 + DW'(r_sq);
                end
                if (!w_issue && !r_rd_v && !r_sq_v) begin
                    n_state = S_MUL;
                    n_k     = '0;
                    n_nsh   = r_count;
                    n_s1sq  = '0;
                    n_wide  = '0;
                end
            end

            S_MUL: begin
                // S1^2 from three partial products, n*S2 by shift and add
                n_sq_v = (r_k < KW'(3));
                if (r_sq_v) begin
                    if (r_k == KW'(1)) begin
                        n_s1sq = r_s1sq + DW'(r_sq);
                    end else if (r_k == KW'(2)) begin
                        n_s1sq = r_s1sq + (DW'(r_sq) << (FREQW + 1));
                    end else begin
                        n_s1sq = r_s1sq + (DW'(r_sq) << (2 * FREQW));
                    end
                end
                if (r_nsh[0]) begin
                    n_wide = r_wide + r_s2;
                end
                n_s2  = r_s2 << 1;
                n_nsh = r_nsh >> 1;
                if (r_k == KW'(MSTEPS - 1)) begin
                    n_state = S_DIFF;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end

            S_DIFF: begin
                n_wide  = r_wide - r_s1sq;
                n_rem   = '0;
                n_root  = '0;
                n_k     = '0;
                n_state = S_SQRT;
            end

            S_SQRT: begin
                // two radicand bits per step, one root bit
                if (w_rem_sh >= w_trial) begin
                    n_rem  = w_rem_sh - w_trial;
                    n_root = {r_root[RW-2:0], 1'b1};
                end else begin
                    n_rem  = w_rem_sh;
                    n_root = {r_root[RW-2:0], 1'b0};
                end
                n_wide = r_wide << 2;
                if (r_k == KW'(RW - 1)) begin
                    n_state = S_SCALE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end

            S_SCALE: begin
                // ratio reaches full scale exactly when root >= S1
                if (r_root >= r_s1) begin
                    n_score = '0;
                    n_state = S_DONE;
                end else begin
                    n_rem   = (RW+2)'(w_num >> SCW);
                    n_wide  = DW'(w_num[SCW-1:0]);
                    n_quo   = '0;
                    n_k     = '0;
                    n_state = S_DIV;
                end
            end

            S_DIV: begin
                if (w_dsh >= w_div) begin
                    n_rem = w_dsh - w_div;
                    n_quo = {r_quo[SCW-2:0], 1'b1};
                end else begin
                    n_rem = w_dsh;
                    n_quo = {r_quo[SCW-2:0], 1'b0};
                end
                n_wide = r_wide << 1;
                if (r_k == KW'(SCW - 1)) begin
                    n_score = FULL_SCORE - n_quo;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + KW'(1);
                end
            end

            S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid     = 1'b1;
                    n_out.stability = r_score;
                    n_out.accepted  = r_accepted;
                    n_out.fill      = r_count;
                    n_state         = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_min       <= MIN_RESET;
            r_slot      <= '0;
            r_count     <= '0;
            r_score     <= FULL_SCORE;
            r_out_valid <= 1'b0;
            r_rd_v      <= 1'b0;
            r_sq_v      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_min       <= n_min;
            r_slot      <= n_slot;
            r_count     <= n_count;
            r_score     <= n_score;
            r_out_valid <= n_out_valid;
            r_rd_v      <= n_rd_v;
            r_sq_v      <= n_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_accepted <= n_accepted;
        r_idx      <= n_idx;
        r_sq       <= w_prod;
        r_s1       <= n_s1;
        r_s2       <= n_s2;
        r_s1sq     <= n_s1sq;
        r_wide     <= n_wide;
        r_nsh      <= n_nsh;
        r_k        <= n_k;
        r_rem      <= n_rem;
        r_root     <= n_root;
        r_quo      <= n_quo;
        r_out      <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ----- rtl/frequency_stability_metric_top.sv -----
// Top level of the frequency stability metric block.
//
//   Channel   Direction  Handshake               Payload
//   in        input      i_in_valid / o_in_stall  i_in_data  (t_in: func, frequency)
//   out       output     o_out_valid / i_out_stall o_out_data (t_out: stability, accepted, fill)
//   cfg       input      i_cfg_we                 i_cfg_data (min_count)
//
// An add that computes a score sums over the n ring entries, forms the products, takes the
// bit-serial square root and then divides, unless the root already reaches S1.
// Clear, zero frequency and adds below min_count go from idle straight to the done state.
// Reset is synchronous; the ring is not cleared, only the entry count and write slot.
// A stalled output holds the engine in its done state; the input stage and the command
// queue still take up to QUEUE_DEPTH + 1 more transfers before o_in_stall rises.
`default_nettype none

module frequency_stability_metric_top #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  fstab_pkg::t_in             i_in_data,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output fstab_pkg::t_out            o_out_data,
    input  logic                       i_cfg_we,
    input  logic [fstab_pkg::MINW-1:0] i_cfg_data
);

    import fstab_pkg::*;

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_cmd_stall;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_stall;

    fstab_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_stall (w_cmd_stall)
    );

    fstab_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_cmd_valid),
        .i_push_data  (w_cmd),
        .o_push_stall (w_cmd_stall),
        .o_pop_valid  (w_q_valid),
        .o_pop_data   (w_q_cmd),
        .i_pop_stall  (w_q_stall)
    );

    fstab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_stall (w_q_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef NO_ASSERTIONS
    a_score_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.stability <= FULL_SCORE))
        else $error("stability above full scale");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepted) |-> (o_out_data.fill != '0))
        else $error("stored sample reported with an empty ring");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.fill <= CW'(WINDOW)))
        else $error("fill exceeds ring size");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_cmd_valid && w_cmd_stall))
        else $error("input stalled with a free input stage");
`endif

endmodule

`default_nettype wire

// ----- bench/frequency_stability_metric_checker.sv -----
// Channel monitor, stability score predictor and result checker for the frequency stability block.
`timescale 1ns / 100ps

module frequency_stability_metric_checker
    import fstab_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  t_in             i_in_data,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  t_out            i_out_data,
    input  logic            i_cfg_we,
    input  logic [MINW-1:0] i_cfg_data,
    output int              o_errors,
    output int              o_pending
);

    localparam int MAX_REPORTS = 50;

    // Shadow state of the measurement window
    logic [FREQW-1:0] samples [WINDOW];
    logic [LW-1:0]    next_slot;
    logic [CW-1:0]    held_count;
    logic [SCW-1:0]   held_score;
    logic [MINW-1:0]  min_needed;

    t_out due_readings [$];
    t_out oldest;
    int   mismatches = 0;

    // Exact 100% minus coefficient of variation over the held samples, percent * 256
    function automatic logic [SCW-1:0] window_score();
        logic [127:0] sum1;
        logic [127:0] sum2;
        logic [127:0] spread;
        logic [127:0] root;
        logic [127:0] trial;
        logic [127:0] ratio;
        int           i;
        int           b;
        sum1 = '0;
        sum2 = '0;
        for (i = 0; i < held_count; i++) begin
            sum1 = sum1 + samples[i];
            sum2 = sum2 + {96'd0, samples[i]} * {96'd0, samples[i]};
        end
        spread = sum2 * held_count - sum1 * sum1;
        root = '0;
        for (b = 63; b >= 0; b--) begin
            trial = root | (128'd1 << b);
            if (trial * trial <= spread) root = trial;
        end
        ratio = root * FULL_SCORE / sum1;
        if (ratio >= FULL_SCORE) return '0;
        return FULL_SCORE - ratio[SCW-1:0];
    endfunction

    task automatic predict_transfer(input t_in item);
        t_out due;
        due.accepted = 1'b0;
        if ({1'b0, item.func} == OP_CLEAR) begin
            next_slot  = '0;
            held_count = '0;
            held_score = FULL_SCORE;
        end else if (item.frequency != '0) begin
            due.accepted = 1'b1;
            samples[next_slot] = item.frequency;
            next_slot = next_slot + 1'b1;
            if (held_count < WINDOW) held_count = held_count + 1'b1;
            held_score = (held_count < min_needed) ? FULL_SCORE : window_score();
        end
        due.stability = held_score;
        due.fill      = held_count;
        due_readings.push_back(due);
    endtask

    task automatic check_field(input string name, input int due, input int got);
        if (due != got) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, due, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            next_slot  = '0;
            held_count = '0;
            held_score = FULL_SCORE;
            min_needed = MIN_RESET;
            due_readings.delete();
        end else begin
            if (i_cfg_we) min_needed = i_cfg_data;
            // Predict before popping so a same-edge result still finds its entry
            if (i_in_valid && !i_in_stall) predict_transfer(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (due_readings.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                                 $time, i_out_data.stability, i_out_data.accepted,
                                 i_out_data.fill);
                end else begin
                    oldest = due_readings.pop_front();
                    check_field("stability", oldest.stability, i_out_data.stability);
                    check_field("accepted", oldest.accepted, i_out_data.accepted);
                    check_field("fill", oldest.fill, i_out_data.fill);
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= due_readings.size();
    end

endmodule

// ----- bench/testbench.sv -----
// Stimulus, handshake pacing and verdict for the frequency stability block.
`timescale 1ns / 100ps

module testbench;
    import fstab_pkg::*;

    localparam int SEGMENT_ITEMS = 317;
    localparam int SETTLE_CYCLES = 100;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            i_in_valid  = 1'b0;
    t_in             i_in_data   = '0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic            i_out_stall = 1'b0;
    t_out            o_out_data;
    logic            i_cfg_we    = 1'b0;
    logic [MINW-1:0] i_cfg_data  = '0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int failures;
    int pending;
    int sample_count   = 0;
    int zero_count     = 0;
    int clear_count    = 0;
    int setting_count  = 0;

    frequency_stability_metric_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    frequency_stability_metric_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (failures),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Present one reading after random idle cycles and hold it until the transfer
    task automatic push_reading(input t_in item);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_op(input t_op op, input logic [FREQW-1:0] freq);
        t_in item;
        item.func      = (op == OP_CLEAR);
        item.frequency = freq;
        if (op == OP_CLEAR) clear_count++;
        else if (freq == '0) zero_count++;
        else sample_count++;
        push_reading(item);
    endtask

    // Stop sending and wait for every predicted score to come back
    task automatic await_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_min_count(input logic [MINW-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        setting_count++;
    endtask

    // Bursts of readings around a common character, with stray zeros and clears
    task automatic run_segment(input int items, input bit hold_midway);
        int               sent;
        int               burst_len;
        int               style;
        int               shift;
        int               roll;
        int               j;
        logic [FREQW-1:0] base;
        logic [FREQW-1:0] value;
        sent = 0;
        while (sent < items) begin
            burst_len = $urandom_range(40, 4);
            style     = $urandom_range(3);
            shift     = $urandom_range(31);
            base      = (style == 2) ? $urandom_range(255, 1) : $urandom;
            if ($urandom_range(99) < 25) begin
                send_op(OP_CLEAR, $urandom);
                sent++;
            end
            for (j = 0; j < burst_len && sent < items; j++) begin
                if (hold_midway && sent >= items / 2) begin
                    await_drain();
                    hold_midway = 1'b0;
                end
                roll = $urandom_range(99);
                if (roll < 3) begin
                    value = '0;
                end else begin
                    case (style)
                        0: value = base ^ ($urandom >> shift);
                        1: value = $urandom;
                        2: value = $urandom_range(255, 1);
                        // far-apart pairs drive the ratio past full scale
                        default: value = $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(15)
                                                           : $urandom_range(16, 1);
                    endcase
                end
                if (roll >= 3 && roll < 5) send_op(OP_CLEAR, value);
                else send_op(OP_ADD, value);
                sent++;
            end
        end
    endtask

    initial begin
        logic [MINW-1:0] min_plan [6];
        int              seg;
        int              k;
        min_plan[0] = 5'd16;
        min_plan[1] = 5'd1;
        min_plan[2] = 5'($urandom_range(15, 2));
        min_plan[3] = 5'd0;
        min_plan[4] = 5'd17;
        min_plan[5] = MIN_RESET;
        send_idle_pct  = 23;
        recv_stall_pct = 77;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Clear on empty, ignored zero, warm-up below the minimum, saturated spread
        send_op(OP_CLEAR, 32'hFFFF_FFFF);
        send_op(OP_ADD, '0);
        repeat (3) send_op(OP_ADD, 32'd1);
        send_op(OP_ADD, 32'hFFFF_FFFF);
        send_op(OP_ADD, '0);
        // Minimum of zero while the ring wraps
        await_drain();
        write_min_count(5'd0);
        for (k = 0; k < 13; k++)
            send_op(OP_ADD, k[0] ? 32'h7FFF_FFF0 - k : 32'h8000_0000 + k);
        // Minimum above the window, then clear with a zero frequency
        await_drain();
        write_min_count(5'd31);
        send_op(OP_ADD, 32'hA5A5_5A5A);
        send_op(OP_CLEAR, '0);

        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct  = 77;
                recv_stall_pct = 23;
            end else if (seg == 4) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            await_drain();
            write_min_count(min_plan[seg]);
            run_segment(SEGMENT_ITEMS, seg == 0);
        end

        await_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Run covered %0d samples, %0d zero readings and %0d clears over %0d min_count values",
                 sample_count, zero_count, clear_count, setting_count);
        $display("with sender gaps and output stalls in three mixes plus a full drain mid-run.");
        if (failures == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
